// ===== rtl/priority_ready_queue_macros.svh =====
// Assertion macros used by the priority ready queue datapath.
`ifndef PRIORITY_READY_QUEUE_MACROS_SVH
`define PRIORITY_READY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define PRQ_ASSERT(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("priority_ready_queue: invariant violated");
`define PRQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("priority_ready_queue: implication violated");
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority_ready_queue: next-cycle check violated");
`else
`define PRQ_ASSERT(label, clk, rst, cond)
`define PRQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define PRQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/prq_pkg.sv =====
// Shared types and codes of the priority ready queue.
`default_nettype none
package prq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef logic [1:0] prq_status_t;

  localparam prq_status_t ST_OK        = 2'd0;
  localparam prq_status_t ST_EMPTY     = 2'd1;
  localparam prq_status_t ST_MISSING   = 2'd2;
  localparam prq_status_t ST_DUPLICATE = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [3:0] proc_id;
    logic [7:0] priority_req;
  } prq_req_t;

  typedef struct packed {
    logic        [3:0] head_id;
    logic              queue_empty;
    prq_status_t       status;
  } prq_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_INS_RD,
    S_WR_NEW,
    S_WR_PREV,
    S_REM_RD,
    S_DONE
  } prq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load_req;
    logic        start;
    logic        advance;
    logic        rd_link;
    logic        set_status;
    prq_status_t status_code;
    logic        wr_new;
    logic        wr_prev;
    logic        unlink;
    logic        load_res;
  } prq_dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_insert;
    logic id_valid;
    logic id_queued;
    logic head_valid;
    logic rd_prio_lower;
    logic rd_is_id;
    logic rd_link_valid;
    logic at_head;
    logic res_busy;
  } prq_dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/prq_stream_if.sv =====
// Valid/ready stream interface carrying one payload struct.
`default_nettype none
interface prq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/prq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/prq_ctrl.sv =====
// Controller state machine that sequences checks, list walks and link updates.
`default_nettype none
module prq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  prq_pkg::prq_dp_stat_t stat,
  output prq_pkg::prq_dp_cmd_t  cmd
);
  import prq_pkg::*;

  prq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.is_insert) begin
          if (!stat.id_valid || stat.id_queued) state_next = S_DONE;
          else if (stat.head_valid) state_next = S_INS_RD;
          else state_next = S_WR_NEW;
        end else begin
          if (!stat.head_valid || !stat.id_valid || !stat.id_queued) state_next = S_DONE;
          else state_next = S_REM_RD;
        end
      end
      S_INS_RD: begin
        if (stat.rd_prio_lower || !stat.rd_link_valid) state_next = S_WR_NEW;
      end
      S_WR_NEW: begin
        state_next = stat.at_head ? S_DONE : S_WR_PREV;
      end
      S_WR_PREV: state_next = S_DONE;
      S_REM_RD: begin
        if (stat.rd_is_id || !stat.rd_link_valid) state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.res_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.status_code = ST_OK;
    req_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready    = 1'b1;
        cmd.load_req = req_valid;
      end
      S_CHECK: begin
        cmd.set_status = 1'b1;
        cmd.start      = 1'b1;
        if (stat.is_insert) begin
          if (!stat.id_valid) cmd.status_code = ST_MISSING;
          else if (stat.id_queued) cmd.status_code = ST_DUPLICATE;
        end else begin
          if (!stat.head_valid) cmd.status_code = ST_EMPTY;
          else if (!stat.id_valid || !stat.id_queued) cmd.status_code = ST_MISSING;
        end
      end
      S_INS_RD: begin
        if (!stat.rd_prio_lower) begin
          cmd.advance = 1'b1;
          cmd.rd_link = 1'b1;
        end
      end
      S_WR_NEW:  cmd.wr_new = 1'b1;
      S_WR_PREV: cmd.wr_prev = 1'b1;
      S_REM_RD: begin
        if (stat.rd_is_id) begin
          cmd.unlink = 1'b1;
        end else begin
          cmd.advance = 1'b1;
          cmd.rd_link = 1'b1;
          if (!stat.rd_link_valid) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_MISSING;
          end
        end
      end
      S_DONE: cmd.load_res = !stat.res_busy;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/prq_dpath.sv =====
// Datapath: link/priority RAM, queued flags, walk registers and result register.
`default_nettype none
`include "priority_ready_queue_macros.svh"
module prq_dpath #(
  parameter int MAX_PROCS = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  prq_pkg::prq_dp_cmd_t  cmd,
  output prq_pkg::prq_dp_stat_t stat,
  input  prq_pkg::prq_req_t     req_data,
  input  logic                  rsp_ready,
  output logic                  rsp_valid,
  output prq_pkg::prq_rsp_t     rsp_data
);
  import prq_pkg::*;

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int LW    = 1 + IDX_W + PRIO_BITS;

  logic                 cmd_r;
  logic [3:0]           id_r;
  logic [PRIO_BITS-1:0] prio_r;
  prq_status_t          status_r;

  logic [IDX_W-1:0]     head;
  logic                 head_valid;
  logic [IDX_W-1:0]     cur;
  logic [PRIO_BITS-1:0] cur_prio;
  logic [IDX_W-1:0]     nx;
  logic                 nx_valid;
  logic                 at_head;
  logic [MAX_PROCS-1:0] qmark;

  logic [IDX_W-1:0]     id_idx;
  logic                 id_valid;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [LW-1:0]        ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [LW-1:0]        ram_rdata;

  logic                 r_link_valid;
  logic [IDX_W-1:0]     r_link;
  logic [PRIO_BITS-1:0] r_prio;

  assign id_idx   = IDX_W'(id_r);
  assign id_valid = 32'(id_r) < MAX_PROCS;

  // Each RAM word holds an entry's successor link and its priority.
  assign r_link_valid = ram_rdata[LW-1];
  assign r_link       = ram_rdata[LW-2 -: IDX_W];
  assign r_prio       = ram_rdata[PRIO_BITS-1:0];

  // The walk reads the head first, then follows the link just read.
  assign ram_raddr = cmd.rd_link ? r_link : head;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = {1'b1, id_idx, cur_prio};
    if (cmd.wr_new) begin
      ram_we    = 1'b1;
      ram_waddr = id_idx;
      ram_wdata = {nx_valid, nx, prio_r};
    end else if (cmd.wr_prev) begin
      ram_we = 1'b1;
    end else if (cmd.unlink && !at_head) begin
      ram_we    = 1'b1;
      ram_wdata = {r_link_valid, r_link, cur_prio};
    end
  end

  prq_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_PROCS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cmd_r  <= req_data.cmd;
      id_r   <= req_data.proc_id;
      prio_r <= PRIO_BITS'(req_data.priority_req);
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.start) begin
      nx       <= head;
      nx_valid <= head_valid;
    end else if (cmd.advance) begin
      cur      <= nx;
      cur_prio <= r_prio;
      nx       <= r_link;
      nx_valid <= r_link_valid;
    end
    if (cmd.load_res) begin
      rsp_data.head_id     <= head_valid ? 4'(head) : 4'd0;
      rsp_data.queue_empty <= !head_valid;
      rsp_data.status      <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      head       <= '0;
      at_head    <= 1'b0;
      qmark      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.start) begin
        at_head <= 1'b1;
      end else if (cmd.advance) begin
        at_head <= 1'b0;
      end
      if (cmd.wr_new) begin
        qmark[id_idx] <= 1'b1;
        if (at_head) begin
          head       <= id_idx;
          head_valid <= 1'b1;
        end
      end
      if (cmd.unlink) begin
        qmark[id_idx] <= 1'b0;
        if (at_head) begin
          head       <= r_link;
          head_valid <= r_link_valid;
        end
      end
      if (cmd.load_res) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign stat.is_insert     = (cmd_r == CMD_INSERT);
  assign stat.id_valid      = id_valid;
  assign stat.id_queued     = id_valid && qmark[id_idx];
  assign stat.head_valid    = head_valid;
  assign stat.rd_prio_lower = r_prio < prio_r;
  assign stat.rd_is_id      = (nx == id_idx);
  assign stat.rd_link_valid = r_link_valid;
  assign stat.at_head       = at_head;
  assign stat.res_busy      = rsp_valid && !rsp_ready;

  // The queue is empty exactly when no id carries a queued flag.
  `PRQ_ASSERT(a_empty_matches_flags, clk, rst, head_valid == (|qmark))
  `PRQ_ASSERT_IMP(a_head_is_queued, clk, rst, head_valid, qmark[head])
  `PRQ_ASSERT_IMP(a_insert_ok_marks, clk, rst, cmd.load_res && status_r == ST_OK && cmd_r == CMD_INSERT, qmark[id_idx])
  `PRQ_ASSERT_NEXT(a_result_presented, clk, rst, cmd.load_res, rsp_valid)
endmodule
`default_nettype wire

// ===== rtl/priority_ready_queue.sv =====
// Top level of the priority ready queue: controller, datapath and stream ports.
//
//   Port  Dir  Transaction carries
//   req   in   cmd, proc_id, priority_req
//   rsp   out  head_id, queue_empty, status
//
// A rejected transaction goes straight to the result. A walk reads one RAM
// entry per cycle: a remove walks to the id, an insert to the first entry
// of lower priority, then writes the new entry and any predecessor's link.
// Reset clears the queued flags and the head at once, with no clearing pass.
// A finished result waits in the output register while the next request is
// accepted; that request completes once the register has been taken.
`default_nettype none
module priority_ready_queue #(
  parameter int MAX_PROCS = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  prq_stream_if.sink   req,
  prq_stream_if.source rsp
);
  import prq_pkg::*;

  prq_dp_cmd_t  dp_cmd;
  prq_dp_stat_t dp_stat;

  prq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  prq_dpath #(
    .MAX_PROCS(MAX_PROCS),
    .PRIO_BITS(PRIO_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .req_data (req.data),
    .rsp_ready(rsp.ready),
    .rsp_valid(rsp.valid),
    .rsp_data (rsp.data)
  );
endmodule
`default_nettype wire
